// ===== rtl/ptb_pkg.sv =====
// Package: shared constants and codes for the periodic timer bank.
package ptb_pkg;
    localparam int NumSlots = 16;
    localparam int SlotW = 4;
    localparam int MaxResults = 16;

    localparam logic [3:0] FuncTick = 4'd0;
    localparam logic [3:0] FuncCreate = 4'd1;
    localparam logic [3:0] FuncDelete = 4'd2;
    localparam logic [3:0] FuncPause = 4'd3;
    localparam logic [3:0] FuncResume = 4'd4;
    localparam logic [3:0] FuncReady = 4'd5;
    localparam logic [3:0] FuncReset = 4'd6;
    localparam logic [3:0] FuncSetPer = 4'd7;
    localparam logic [3:0] FuncSetCnt = 4'd8;
    localparam logic [3:0] FuncRead = 4'd9;

    localparam logic [1:0] KindFire = 2'd0;
    localparam logic [1:0] KindIdle = 2'd1;
    localparam logic [1:0] KindAck = 2'd2;
    localparam logic [1:0] KindRead = 2'd3;

    // memory word: elapsed, period, remaining
    localparam int WordW = 80;
endpackage

// ===== rtl/periodic_timer_bank.sv =====
// Top level: bank of periodic timer slots kept in one RAM.
// Usage: drive i_valid with a command (func, slot and operands); it is taken
// when i_valid is high and o_stall is low. Each command yields one result,
// a tick yields one result per slot that fired (at most 16, slot order) or
// a single idle result; o_last marks the final result of a command.
// Results leave through an output register with o_valid / i_stall; while a
// full output register is stalled the sequencer waits in place.
// A command passes through a read state and then a modify/write state, which
// loads its result into the output register; the next command is taken once
// the sequencer is back in its idle state.
// A tick visits every slot with a read state and a modify/write state, then
// a flush state for the last fire (or idle) result, which carries o_last; the
// next item is taken once the sequencer is idle again, later when results
// are stalled.
// The last fire of a tick is held in a pending register until the walk ends
// so that o_last can be set on it.
// One item is worked on at a time.
// Reset clears the valid bits, the total time, the sequencer state, the output
// and pending valid flags and the result count; the slot RAM itself is not cleared (valid bits mask stale entries).
module periodic_timer_bank (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_func,
    input  logic [3:0]  i_slot,
    input  logic [31:0] i_period_ms,
    input  logic [14:0] i_repeat_count,
    input  logic [15:0] i_elapsed_ms,
    input  logic        i_clear_flag,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_fired_slot,
    output logic        o_expired,
    output logic signed [15:0] o_count_value,
    output logic [31:0] o_total_time,
    output logic        o_status,
    output logic        o_last
);
    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StRead = 2'd1;
    localparam logic [1:0] StMod = 2'd2;
    localparam logic [1:0] StFlush = 2'd3;

    logic [1:0] r_state, n_state;
    logic [ptb_pkg::NumSlots-1:0] r_vld, n_vld;
    logic [31:0] r_total, n_total;
    logic [3:0]  r_func;
    logic [ptb_pkg::SlotW-1:0] r_slot, n_slot;
    logic [31:0] r_per;
    logic [14:0] r_cnt;
    logic [15:0] r_ms;
    logic        r_clr;
    logic [4:0]  r_nres, n_nres;

    // pending fire of the running tick
    logic        r_pv, n_pv;
    logic [ptb_pkg::SlotW-1:0] r_ps, n_ps;
    logic        r_pe, n_pe;
    logic [15:0] r_pc, n_pc;

    logic        r_ov, n_ov;
    logic [1:0]  r_kind, n_kind;
    logic [3:0]  r_oslot, n_oslot;
    logic        r_exp, n_exp;
    logic [15:0] r_cv, n_cv;
    logic [31:0] r_ot, n_ot;
    logic        r_st, n_st;
    logic        r_last, n_last;

    logic        we;
    logic [ptb_pkg::WordW-1:0] wdata, rdata;

    ptb_ram #(.Width(ptb_pkg::WordW), .Depth(ptb_pkg::NumSlots)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_slot), .i_wdata(wdata),
        .i_raddr(r_slot), .o_rdata(rdata)
    );

    logic        accept, out_free;
    logic [31:0] el, per, el_add, el_new;
    logic signed [15:0] rem, rem_new;
    logic        live, is_last_slot, fire, freed;

    assign accept = i_valid && !o_stall;
    assign out_free = !r_ov || !i_stall;
    assign o_stall = r_state != StIdle;
    assign el = rdata[79:48];
    assign per = rdata[47:16];
    assign rem = rdata[15:0];
    assign live = r_vld[r_slot];
    assign is_last_slot = r_slot == ptb_pkg::SlotW'(ptb_pkg::NumSlots - 1);
    assign el_add = el + {16'd0, r_ms};

    always_comb begin
        n_state = r_state;
        n_vld = r_vld;
        n_total = r_total;
        n_slot = r_slot;
        n_nres = r_nres;
        n_pv = r_pv;
        n_ps = r_ps;
        n_pe = r_pe;
        n_pc = r_pc;
        n_ov = r_ov && i_stall;
        n_kind = r_kind;
        n_oslot = r_oslot;
        n_exp = r_exp;
        n_cv = r_cv;
        n_ot = r_ot;
        n_st = r_st;
        n_last = r_last;
        we = 1'b0;
        wdata = rdata;
        el_new = el_add;
        rem_new = rem;
        fire = 1'b0;
        freed = 1'b0;
        case (r_state)
            StIdle: begin
                if (accept) begin
                    n_slot = (i_func == ptb_pkg::FuncTick) ? '0 : i_slot;
                    n_nres = '0;
                    n_pv = 1'b0;
                    if (i_func == ptb_pkg::FuncTick) begin
                        n_total = r_total + {16'd0, i_elapsed_ms};
                    end
                    n_state = StRead;
                end
            end
            StRead: n_state = StMod;
            StMod: begin
                if (out_free) begin
                    if (r_func == ptb_pkg::FuncTick) begin
                        if (live && !rem[15]) begin
                            we = 1'b1;
                            if (el_add >= per) begin
                                fire = 1'b1;
                                el_new = el_add - per;
                                if (rem != 16'sd0) begin
                                    rem_new = rem - 16'sd1;
                                    if (rem == 16'sd1) begin
                                        n_vld[r_slot] = 1'b0;
                                        freed = 1'b1;
                                    end
                                end
                            end
                            wdata = {el_new, per, rem_new};
                        end
                        if (fire && r_nres < 5'(ptb_pkg::MaxResults)) begin
                            n_nres = r_nres + 5'd1;
                            n_pv = 1'b1;
                            n_ps = r_slot;
                            n_pe = freed;
                            n_pc = rem_new;
                            // a newer fire pushes the pending one out
                            if (r_pv) begin
                                n_ov = 1'b1;
                                n_kind = ptb_pkg::KindFire;
                                n_oslot = r_ps;
                                n_exp = r_pe;
                                n_cv = r_pc;
                                n_ot = r_total;
                                n_st = 1'b0;
                                n_last = 1'b0;
                            end
                        end
                        if (is_last_slot) begin
                            n_state = StFlush;
                        end else begin
                            n_slot = r_slot + 1'b1;
                            n_state = StRead;
                        end
                    end else begin
                        n_ov = 1'b1;
                        n_exp = 1'b0;
                        n_cv = '0;
                        n_st = 1'b0;
                        n_oslot = r_slot;
                        n_ot = r_total;
                        n_last = 1'b1;
                        n_state = StIdle;
                        if (r_func == ptb_pkg::FuncRead) begin
                            n_kind = ptb_pkg::KindRead;
                            n_st = !live;
                            n_cv = live ? rem : -16'sd1;
                        end else begin
                            n_kind = ptb_pkg::KindAck;
                            n_st = !live && r_func != ptb_pkg::FuncCreate
                                && r_func <= ptb_pkg::FuncSetCnt;
                            if (r_func == ptb_pkg::FuncCreate) begin
                                we = 1'b1;
                                wdata = {32'd0, r_per, 1'b0, r_cnt};
                                n_vld[r_slot] = 1'b1;
                            end else if (live) begin
                                we = 1'b1;
                                case (r_func)
                                    ptb_pkg::FuncDelete: begin
                                        we = 1'b0;
                                        n_vld[r_slot] = 1'b0;
                                    end
                                    ptb_pkg::FuncPause:
                                        if (!rem[15]) wdata[15:0] = -rem - 16'sd1;
                                    ptb_pkg::FuncResume:
                                        if (rem[15]) wdata[15:0] = -rem - 16'sd1;
                                    ptb_pkg::FuncReady:
                                        wdata[79:48] = r_clr ? per : el + per;
                                    ptb_pkg::FuncReset: wdata[79:48] = '0;
                                    ptb_pkg::FuncSetPer: wdata[79:16] = {32'd0, r_per};
                                    ptb_pkg::FuncSetCnt: wdata[15:0] = {1'b0, r_cnt};
                                    default: we = 1'b0;
                                endcase
                            end
                        end
                    end
                end
            end
            StFlush: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_ot = r_total;
                    n_st = 1'b0;
                    n_last = 1'b1;
                    n_pv = 1'b0;
                    n_state = StIdle;
                    if (r_pv) begin
                        n_kind = ptb_pkg::KindFire;
                        n_oslot = r_ps;
                        n_exp = r_pe;
                        n_cv = r_pc;
                    end else begin
                        n_kind = ptb_pkg::KindIdle;
                        n_oslot = '0;
                        n_exp = 1'b0;
                        n_cv = '0;
                    end
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_vld <= '0;
            r_total <= '0;
            r_ov <= 1'b0;
            r_pv <= 1'b0;
            r_nres <= '0;
        end else begin
            r_state <= n_state;
            r_vld <= n_vld;
            r_total <= n_total;
            r_ov <= n_ov;
            r_pv <= n_pv;
            r_nres <= n_nres;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (accept) begin
            r_func <= i_func;
            r_per <= i_period_ms;
            r_cnt <= i_repeat_count;
            r_ms <= i_elapsed_ms;
            r_clr <= i_clear_flag;
        end
        r_ps <= n_ps;
        r_pe <= n_pe;
        r_pc <= n_pc;
        r_kind <= n_kind;
        r_oslot <= n_oslot;
        r_exp <= n_exp;
        r_cv <= n_cv;
        r_ot <= n_ot;
        r_st <= n_st;
        r_last <= n_last;
    end

    assign o_valid = r_ov;
    assign o_kind = r_kind;
    assign o_fired_slot = r_oslot;
    assign o_expired = r_exp;
    assign o_count_value = r_cv;
    assign o_total_time = r_ot;
    assign o_status = r_st;
    assign o_last = r_last;

`ifndef SYNTH
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != StIdle) |-> o_stall) else $error("busy without stall");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_kind) && $stable(o_fired_slot)
        && $stable(o_expired) && $stable(o_count_value) && $stable(o_total_time)
        && $stable(o_status) && $stable(o_last)))
        else $error("stalled result changed");
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != StIdle) |=> $stable(r_total) || $past(r_state) == StIdle)
        else $error("total changed mid item");
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == ptb_pkg::KindIdle) |-> o_last)
        else $error("idle result without last");
`endif
endmodule

// ===== rtl/ptb_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module ptb_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sim/timer_bank_checker.sv =====
// Checker for the periodic timer bank: predicts every result and compares it.
module timer_bank_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [3:0]  i_func,
    input  logic [3:0]  i_slot,
    input  logic [31:0] i_period_ms,
    input  logic [14:0] i_repeat_count,
    input  logic [15:0] i_elapsed_ms,
    input  logic        i_clear_flag,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_fired_slot,
    input  logic        i_expired,
    input  logic signed [15:0] i_count_value,
    input  logic [31:0] i_total_time,
    input  logic        i_status,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         slot;
        logic               expired;
        logic signed [15:0] count;
        logic [31:0]        total;
        logic               status;
        logic               last;
    } t_timer_result;

    t_timer_result due_results[$];

    logic               live_q [ptb_pkg::NumSlots];
    logic [31:0]        elapsed_q [ptb_pkg::NumSlots];
    logic [31:0]        period_q [ptb_pkg::NumSlots];
    logic signed [15:0] repeats_q [ptb_pkg::NumSlots];
    logic [31:0]        total_q;
    int                 mismatches;
    int                 pending_q;

    function automatic t_timer_result make_result(logic [1:0] kind, logic [3:0] slot,
                                                  logic expired, logic signed [15:0] count,
                                                  logic status);
        t_timer_result r;
        r.kind = kind;
        r.slot = slot;
        r.expired = expired;
        r.count = count;
        r.total = total_q;
        r.status = status;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic apply_tick(input logic [15:0] ms);
        int fired;
        logic expired;
        fired = 0;
        total_q = total_q + 32'(ms);
        for (int i = 0; i < ptb_pkg::NumSlots; i++) begin
            expired = 1'b0;
            if (live_q[i] && repeats_q[i] >= 0) begin
                elapsed_q[i] = elapsed_q[i] + 32'(ms);
                if (elapsed_q[i] >= period_q[i]) begin
                    elapsed_q[i] = elapsed_q[i] - period_q[i];
                    if (repeats_q[i] > 0) begin
                        repeats_q[i] = repeats_q[i] - 16'sd1;
                        if (repeats_q[i] == 0) begin
                            live_q[i] = 1'b0;
                            expired = 1'b1;
                        end
                    end
                    if (fired < ptb_pkg::MaxResults) begin
                        due_results.push_back(make_result(ptb_pkg::KindFire, 4'(i),
                                                          expired, repeats_q[i], 1'b0));
                        fired++;
                    end
                end
            end
        end
        if (fired == 0)
            due_results.push_back(make_result(ptb_pkg::KindIdle, 4'd0, 1'b0, 16'sd0,
                                              1'b0));
    endtask

    task automatic apply_command();
        logic        live;
        logic        status;
        logic [3:0]  s;
        s = i_slot;
        live = live_q[s];
        status = !live;
        if (i_func == ptb_pkg::FuncTick) begin
            apply_tick(i_elapsed_ms);
        end else if (i_func == ptb_pkg::FuncRead) begin
            due_results.push_back(make_result(ptb_pkg::KindRead, s, 1'b0,
                                              live ? repeats_q[s] : -16'sd1, status));
        end else begin
            if (i_func == ptb_pkg::FuncCreate) begin
                live_q[s] = 1'b1;
                elapsed_q[s] = '0;
                period_q[s] = i_period_ms;
                repeats_q[s] = 16'(i_repeat_count);
                status = 1'b0;
            end else if (i_func > ptb_pkg::FuncRead) begin
                status = 1'b0;
            end else if (live) begin
                case (i_func)
                    ptb_pkg::FuncDelete: live_q[s] = 1'b0;
                    ptb_pkg::FuncPause:
                        if (repeats_q[s] >= 0) repeats_q[s] = -repeats_q[s] - 16'sd1;
                    ptb_pkg::FuncResume:
                        if (repeats_q[s] < 0) repeats_q[s] = -repeats_q[s] - 16'sd1;
                    ptb_pkg::FuncReady: begin
                        if (i_clear_flag)
                            elapsed_q[s] = period_q[s];
                        else
                            elapsed_q[s] = elapsed_q[s] + period_q[s];
                    end
                    ptb_pkg::FuncReset: elapsed_q[s] = '0;
                    ptb_pkg::FuncSetPer: begin
                        elapsed_q[s] = '0;
                        period_q[s] = i_period_ms;
                    end
                    default: repeats_q[s] = 16'(i_repeat_count);
                endcase
            end
            due_results.push_back(make_result(ptb_pkg::KindAck, s, 1'b0, 16'sd0, status));
        end
        due_results[$].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_timer_result want;
        t_timer_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < ptb_pkg::NumSlots; i++)
                live_q[i] = 1'b0;
            total_q = '0;
            due_results.delete();
            mismatches <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_kind, i_fired_slot, i_expired, i_count_value, i_total_time,
                       i_status, i_last};
                if (due_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result %h", got);
                    mismatches <= mismatches + 1;
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("mismatch: expected kind %0d slot %0d exp %0b cnt %0d %s",
                                     want.kind, want.slot, want.expired, want.count,
                                     "");
                            $display("  expected total %0d st %0b last %0b",
                                     want.total, want.status, want.last);
                            $display("  got kind %0d slot %0d exp %0b cnt %0d",
                                     got.kind, got.slot, got.expired, got.count);
                            $display("  got total %0d st %0b last %0b",
                                     got.total, got.status, got.last);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (i_valid && !i_in_stall)
                apply_command();
        end
        pending_q = due_results.size();
    end

    assign o_fail_count = mismatches;
    assign o_pending = pending_q;
endmodule

// ===== sim/periodic_timer_bank_tb.sv =====
// Testbench top: drives timer commands and ticks into the bank and gives the verdict.
module periodic_timer_bank_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 3000;
    localparam int HoldCycles = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [3:0]  i_func = '0;
    logic [3:0]  i_slot = '0;
    logic [31:0] i_period_ms = '0;
    logic [14:0] i_repeat_count = '0;
    logic [15:0] i_elapsed_ms = '0;
    logic        i_clear_flag = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [3:0]  o_fired_slot;
    logic        o_expired;
    logic signed [15:0] o_count_value;
    logic [31:0] o_total_time;
    logic        o_status;
    logic        o_last;
    int          fail_count;
    int          pending;
    int          sent_items = 0;
    int          taken_results = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    periodic_timer_bank dut (.*);

    timer_bank_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_func, .i_slot,
        .i_period_ms, .i_repeat_count, .i_elapsed_ms, .i_clear_flag,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_kind(o_kind),
        .i_fired_slot(o_fired_slot), .i_expired(o_expired),
        .i_count_value(o_count_value), .i_total_time(o_total_time),
        .i_status(o_status), .i_last(o_last), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    function automatic int draw_wait(int n);
        // every third block of 40 transactions runs with no idling
        return ((n / 40) % 3 == 0) ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic send_cmd(logic [3:0] func, logic [3:0] slot, logic [31:0] per,
                            logic [14:0] cnt, logic [15:0] ms, logic clr);
        int gap;
        gap = draw_wait(sent_items);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= func;
        i_slot <= slot;
        i_period_ms <= per;
        i_repeat_count <= cnt;
        i_elapsed_ms <= ms;
        i_clear_flag <= clr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic send_random();
        int r;
        logic [31:0] per;
        logic [14:0] cnt;
        logic [15:0] ms;
        r = $urandom_range(0, 99);
        per = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 120));
        cnt = ($urandom_range(0, 9) == 0) ? 15'($urandom()) : 15'($urandom_range(0, 4));
        ms = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 40));
        if (r < 35)
            send_cmd(ptb_pkg::FuncTick, 4'($urandom()), per, cnt, ms, 1'($urandom()));
        else if (r < 55)
            send_cmd(ptb_pkg::FuncCreate, 4'($urandom()), per, cnt, ms, 1'($urandom()));
        else if (r < 97)
            send_cmd(4'($urandom_range(2, 9)), 4'($urandom()), per, cnt, ms, 1'($urandom()));
        else
            send_cmd(4'($urandom_range(10, 15)), 4'($urandom()), per, cnt, ms,
                     1'($urandom()));
    endtask

    // result side: random stall per transaction plus one long hold-off
    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            if (taken_results == 150) begin
                i_stall <= 1'b1;
                repeat (HoldCycles) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                w = draw_wait(taken_results);
                if (w > 0) begin
                    i_stall <= 1'b1;
                    repeat (w) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            taken_results++;
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < IdleLimit) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
                idle = 0;
            else
                idle++;
        end
        $display("[periodic_timer_bank] ERROR");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: read and commands on empty slots, unused codes, empty tick
        send_cmd(ptb_pkg::FuncRead, 4'd3, '0, '0, '0, 1'b0);
        send_cmd(ptb_pkg::FuncPause, 4'd3, '0, '0, '0, 1'b0);
        send_cmd(4'd10, 4'd0, '0, '0, '0, 1'b0);
        send_cmd(4'd15, 4'd15, '1, '1, '1, 1'b1);
        send_cmd(ptb_pkg::FuncTick, 4'd0, '0, '0, 16'd0, 1'b0);
        send_cmd(ptb_pkg::FuncCreate, 4'd0, 32'd0, 15'd0, '0, 1'b0);
        send_cmd(ptb_pkg::FuncCreate, 4'd15, 32'hFFFF_FFFF, 15'h7FFF, '0, 1'b0);
        send_cmd(ptb_pkg::FuncCreate, 4'd5, 32'd10, 15'd1, '0, 1'b0);
        send_cmd(ptb_pkg::FuncCreate, 4'd5, 32'd20, 15'd2, '0, 1'b0);
        send_cmd(ptb_pkg::FuncTick, 4'd0, '0, '0, 16'hFFFF, 1'b0);
        send_cmd(ptb_pkg::FuncPause, 4'd0, '0, '0, '0, 1'b0);
        send_cmd(ptb_pkg::FuncPause, 4'd0, '0, '0, '0, 1'b0);
        send_cmd(ptb_pkg::FuncRead, 4'd0, '0, '0, '0, 1'b0);
        send_cmd(ptb_pkg::FuncTick, 4'd0, '0, '0, 16'd7, 1'b0);
        send_cmd(ptb_pkg::FuncResume, 4'd0, '0, '0, '0, 1'b0);
        send_cmd(ptb_pkg::FuncResume, 4'd0, '0, '0, '0, 1'b0);
        send_cmd(ptb_pkg::FuncPause, 4'd15, '0, '0, '0, 1'b0);
        send_cmd(ptb_pkg::FuncSetCnt, 4'd15, '0, 15'd3, '0, 1'b0);
        send_cmd(ptb_pkg::FuncReady, 4'd15, '0, '0, '0, 1'b1);
        send_cmd(ptb_pkg::FuncReady, 4'd15, '0, '0, '0, 1'b0);
        send_cmd(ptb_pkg::FuncReset, 4'd5, '0, '0, '0, 1'b0);
        send_cmd(ptb_pkg::FuncSetPer, 4'd5, 32'd3, '0, '0, 1'b0);
        send_cmd(ptb_pkg::FuncTick, 4'd0, '0, '0, 16'd5, 1'b0);
        send_cmd(ptb_pkg::FuncDelete, 4'd0, '0, '0, '0, 1'b0);
        send_cmd(ptb_pkg::FuncRead, 4'd15, '0, '0, '0, 1'b0);
        // fill every slot with period 0 so one tick fires all sixteen
        for (int i = 0; i < ptb_pkg::NumSlots; i++)
            send_cmd(ptb_pkg::FuncCreate, 4'(i), 32'd0, 15'd2, '0, 1'b0);
        send_cmd(ptb_pkg::FuncTick, 4'd0, '0, '0, 16'd1, 1'b0);
        repeat (440) send_random();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[periodic_timer_bank] OK");
        else
            $display("[periodic_timer_bank] ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/ptb_pkg.sv
rtl/ptb_ram.sv
rtl/periodic_timer_bank.sv
sim/timer_bank_checker.sv
sim/periodic_timer_bank_tb.sv
